// File: hw/rtl/mtmq_pkg.sv
// Shared types, operation codes and controller/datapath interface structs
// for the message tag matching queues. No dependencies.
package mtmq_pkg;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] source_rank;
    logic        any_source;
    logic [30:0] msg_tag;
    logic        any_tag;
    logic [15:0] comm_ctx;
    logic [15:0] sender_id;
    logic [15:0] handle_in;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_handle;
    logic [15:0] match_source;
    logic [30:0] match_tag;
    logic [15:0] match_sender;
    logic        appended;
    logic        queue_full;
  } out_t;

  // One queue entry; aux holds wildcard bits (posted) or sender id (unexpected).
  typedef struct packed {
    logic [15:0] ctx;
    logic [15:0] src;
    logic [30:0] tag;
    logic [15:0] aux;
    logic [15:0] hnd;
  } ent_t;

  localparam logic [2:0] FN_POST      = 3'd0;
  localparam logic [2:0] FN_ARRIVE    = 3'd1;
  localparam logic [2:0] FN_PROBE     = 3'd2;
  localparam logic [2:0] FN_CANCEL    = 3'd3;
  localparam logic [2:0] FN_REMOVE    = 3'd4;
  localparam logic [2:0] FN_ARRIVE_MO = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_CMP,
    ST_DECIDE,
    ST_SH_RD,
    ST_SH_WR,
    ST_DEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd_next;
    logic cmp;
    logic inc;
    logic take_k;
    logic shift_wr;
    logic dec;
    logic append;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic empty;
    logic last;
    logic hit;
    logic found;
    logic newest;
    logic removes;
    logic k_last;
    logic sh_last;
    logic out_free;
  } sts_t;

endpackage

// File: hw/rtl/mtmq_ctrl.sv
// Controller state machine for the tag matching queues: scan, shift, emit.
// Depends on mtmq_pkg.
module mtmq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mtmq_pkg::sts_t  sts,
  output mtmq_pkg::cmd_t  cmd,
  output logic            busy
);

  mtmq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtmq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtmq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mtmq_pkg::ST_START;
      end
      mtmq_pkg::ST_START: begin
        if (sts.invalid)    state_nxt = mtmq_pkg::ST_FIN;
        else if (sts.empty) state_nxt = mtmq_pkg::ST_DECIDE;
        else                state_nxt = mtmq_pkg::ST_RD;
      end
      mtmq_pkg::ST_RD: state_nxt = mtmq_pkg::ST_CMP;
      mtmq_pkg::ST_CMP: begin
        if ((sts.hit && !sts.newest) || sts.last) state_nxt = mtmq_pkg::ST_DECIDE;
        else                                      state_nxt = mtmq_pkg::ST_RD;
      end
      mtmq_pkg::ST_DECIDE: begin
        if (sts.found && sts.removes) begin
          state_nxt = sts.k_last ? mtmq_pkg::ST_DEC : mtmq_pkg::ST_SH_RD;
        end else begin
          state_nxt = mtmq_pkg::ST_FIN;
        end
      end
      mtmq_pkg::ST_SH_RD: state_nxt = mtmq_pkg::ST_SH_WR;
      mtmq_pkg::ST_SH_WR: begin
        state_nxt = sts.sh_last ? mtmq_pkg::ST_DEC : mtmq_pkg::ST_SH_RD;
      end
      mtmq_pkg::ST_DEC: state_nxt = mtmq_pkg::ST_FIN;
      mtmq_pkg::ST_FIN: begin
        if (sts.out_free) state_nxt = mtmq_pkg::ST_IDLE;
      end
      default: state_nxt = mtmq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != mtmq_pkg::ST_IDLE);
    case (state_r)
      mtmq_pkg::ST_IDLE:   cmd.load = in_valid;
      mtmq_pkg::ST_START:  cmd.clr = 1'b1;
      mtmq_pkg::ST_RD:     cmd.rd_next = 1'b0;
      mtmq_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        cmd.inc = !((sts.hit && !sts.newest) || sts.last);
      end
      mtmq_pkg::ST_DECIDE: begin
        cmd.take_k = sts.found && sts.removes && !sts.k_last;
        cmd.append = !sts.found;
      end
      mtmq_pkg::ST_SH_RD:  cmd.rd_next = 1'b1;
      mtmq_pkg::ST_SH_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.inc      = !sts.sh_last;
      end
      mtmq_pkg::ST_DEC:    cmd.dec = 1'b1;
      mtmq_pkg::ST_FIN:    cmd.emit = sts.out_free;
      default:             cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/mtmq_dp.sv
// Datapath for the tag matching queues: two entry memories, counts, scan
// index, match record and output register. Depends on mtmq_pkg.
module mtmq_dp #(
  parameter int POSTED_DEPTH     = 64,
  parameter int UNEXPECTED_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mtmq_pkg::in_t   in_data,
  input  mtmq_pkg::cmd_t  cmd,
  input  logic            out_stall,
  output mtmq_pkg::sts_t  sts,
  output logic            out_valid,
  output mtmq_pkg::out_t  out_data
);

  localparam int MAXD = (POSTED_DEPTH > UNEXPECTED_DEPTH) ? POSTED_DEPTH : UNEXPECTED_DEPTH;
  localparam int IW   = $clog2(MAXD);
  localparam int CW   = $clog2(MAXD + 1);
  localparam int PAW  = $clog2(POSTED_DEPTH);
  localparam int UAW  = $clog2(UNEXPECTED_DEPTH);

  mtmq_pkg::ent_t pmem [POSTED_DEPTH];
  mtmq_pkg::ent_t umem [UNEXPECTED_DEPTH];

  mtmq_pkg::in_t  item_r;
  mtmq_pkg::ent_t p_rd_r, u_rd_r, match_r;
  mtmq_pkg::out_t out_r;
  logic [CW-1:0]  p_cnt_r, u_cnt_r;
  logic [IW-1:0]  idx_r, k_r;
  logic           found_r, appended_r, full_r, out_valid_r;

  logic           sel_u, appends, hit, is_full, do_app;
  logic [CW-1:0]  cnt, cnt_m1;
  logic [IW-1:0]  raddr, idx_p1;
  mtmq_pkg::ent_t ent, new_ent;

  assign sel_u = (item_r.func == mtmq_pkg::FN_POST) || (item_r.func == mtmq_pkg::FN_PROBE) ||
                 (item_r.func == mtmq_pkg::FN_REMOVE);
  assign appends = (item_r.func == mtmq_pkg::FN_POST) || (item_r.func == mtmq_pkg::FN_ARRIVE);
  assign cnt    = sel_u ? u_cnt_r : p_cnt_r;
  assign cnt_m1 = cnt - CW'(1);
  assign idx_p1 = idx_r + IW'(1);
  assign raddr  = cmd.rd_next ? idx_p1 : idx_r;
  assign ent    = sel_u ? u_rd_r : p_rd_r;
  assign is_full = sel_u ? (p_cnt_r == CW'(POSTED_DEPTH)) : (u_cnt_r == CW'(UNEXPECTED_DEPTH));
  assign do_app  = cmd.append && appends && !is_full;

  always_comb begin
    new_ent.ctx = item_r.comm_ctx;
    new_ent.src = item_r.source_rank;
    new_ent.tag = item_r.msg_tag;
    new_ent.hnd = item_r.handle_in;
    new_ent.aux = sel_u ? {14'd0, item_r.any_tag, item_r.any_source} : item_r.sender_id;
  end

  always_comb begin
    case (item_r.func)
      mtmq_pkg::FN_POST, mtmq_pkg::FN_PROBE:
        hit = (ent.ctx == item_r.comm_ctx) &&
              (item_r.any_source || ent.src == item_r.source_rank) &&
              (item_r.any_tag || ent.tag == item_r.msg_tag);
      mtmq_pkg::FN_ARRIVE, mtmq_pkg::FN_ARRIVE_MO:
        hit = (ent.ctx == item_r.comm_ctx) &&
              (ent.aux[0] || ent.src == item_r.source_rank) &&
              (ent.aux[1] || ent.tag == item_r.msg_tag);
      mtmq_pkg::FN_CANCEL:
        hit = (ent.hnd == item_r.handle_in);
      mtmq_pkg::FN_REMOVE:
        hit = (ent.aux == item_r.sender_id) && (ent.ctx == item_r.comm_ctx) &&
              (ent.src == item_r.source_rank) && (ent.tag == item_r.msg_tag);
      default: hit = 1'b0;
    endcase
  end

  // Entry memories: one write and one registered read each. A receive that
  // misses appends to the posted queue, an arrival that misses to the
  // unexpected queue.
  always_ff @(posedge clk) begin
    p_rd_r <= pmem[raddr[PAW-1:0]];
    u_rd_r <= umem[raddr[UAW-1:0]];
    if (!sel_u && cmd.shift_wr) pmem[idx_r[PAW-1:0]] <= p_rd_r;
    else if (sel_u && do_app)   pmem[p_cnt_r[PAW-1:0]] <= new_ent;
    if (sel_u && cmd.shift_wr)  umem[idx_r[UAW-1:0]] <= u_rd_r;
    else if (!sel_u && do_app)  umem[u_cnt_r[UAW-1:0]] <= new_ent;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.clr) idx_r <= '0;
    else if (cmd.take_k) idx_r <= k_r;
    else if (cmd.inc) idx_r <= idx_p1;
    if (cmd.cmp && hit) begin
      k_r     <= idx_r;
      match_r <= ent;
    end
    if (cmd.emit) begin
      out_r.found        <= found_r;
      out_r.match_handle <= found_r ? match_r.hnd : 16'd0;
      out_r.match_source <= found_r ? match_r.src : 16'd0;
      out_r.match_tag    <= found_r ? match_r.tag : 31'd0;
      out_r.match_sender <= (found_r && sel_u) ? match_r.aux : 16'd0;
      out_r.appended     <= appended_r;
      out_r.queue_full   <= full_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_cnt_r     <= '0;
      u_cnt_r     <= '0;
      found_r     <= 1'b0;
      appended_r  <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        found_r    <= 1'b0;
        appended_r <= 1'b0;
        full_r     <= 1'b0;
      end else if (cmd.cmp && hit) begin
        found_r <= 1'b1;
      end
      if (cmd.append && appends) begin
        appended_r <= !is_full;
        full_r     <= is_full;
      end
      if (sel_u && do_app)    p_cnt_r <= p_cnt_r + CW'(1);
      if (!sel_u && cmd.dec)  p_cnt_r <= p_cnt_r - CW'(1);
      if (!sel_u && do_app)   u_cnt_r <= u_cnt_r + CW'(1);
      if (sel_u && cmd.dec)   u_cnt_r <= u_cnt_r - CW'(1);
      if (cmd.emit)                   out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.invalid  = (item_r.func > mtmq_pkg::FN_ARRIVE_MO);
    sts.empty    = (cnt == '0);
    sts.last     = (CW'(idx_r) == cnt_m1);
    sts.hit      = hit;
    sts.found    = found_r;
    sts.newest   = (item_r.func == mtmq_pkg::FN_REMOVE);
    sts.removes  = (item_r.func != mtmq_pkg::FN_PROBE);
    sts.k_last   = (CW'(k_r) == cnt_m1);
    sts.sh_last  = (CW'(idx_r) + CW'(1) == cnt_m1);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_p_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_cnt_r <= CW'(POSTED_DEPTH)) else $error("posted count over depth");
  a_u_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    u_cnt_r <= CW'(UNEXPECTED_DEPTH)) else $error("unexpected count over depth");
  a_app_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(appended_r && full_r)) else $error("appended with full");
  a_emit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r) else $error("emitted beat not presented");

endmodule

// File: hw/rtl/message_tag_matching_queues_core.sv
// Top level of the message tag matching queues: controller plus datapath.
// Depends on mtmq_pkg, mtmq_ctrl and mtmq_dp.
//
// Usage: present an operation beat on in_data with in_valid; it is taken
// when in_stall is low. Every beat yields exactly one result beat on
// out_data/out_valid, taken when out_stall is low.
// Operations run one at a time. A beat walks the selected queue one entry
// at a time, each read then compared (one memory read port per queue),
// stopping at the oldest match; removal by sender id walks the whole queue
// to find the newest. Removal then compacts the queue, reading and writing
// back each entry behind the match, and then drops the count. The result
// rises on out_valid in the same cycle as the block can accept again.
// in_stall stays high while an operation runs.
// The result waits in an output register; a stalled receiver holds the
// block in its final state until the beat is taken.
// Reset clears both counts; no memory clearing pass is needed.
module message_tag_matching_queues_core #(
  parameter int POSTED_DEPTH     = 64,
  parameter int UNEXPECTED_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mtmq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mtmq_pkg::out_t  out_data
);

  mtmq_pkg::cmd_t cmd;
  mtmq_pkg::sts_t sts;
  logic           busy;

  mtmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  mtmq_dp #(
    .POSTED_DEPTH     (POSTED_DEPTH),
    .UNEXPECTED_DEPTH (UNEXPECTED_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Accept only while idle.
  assign in_stall = busy;

endmodule
